>>> design/rae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rae_pkg
// Shared types and constants for the register ALU execute block: operation
// codes, default sizes and the control bundles between top and serial ALU.
// ----------------------------------------------------------------------------
package rae_pkg;

  // default sizes
  localparam int NUM_REGS_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the item ports
  localparam int KIND_W    = 3;
  localparam int REG_IDX_W = 5;
  localparam int FIELD_W   = 32;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    OP_MOV = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_REM = 3'd5,
    OP_AND = 3'd6,
    OP_OR  = 3'd7
  } op_t;

  // command into the serial ALU
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_cmd_t;

  // status out of the serial ALU
  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_stat_t;

endpackage : rae_pkg
`default_nettype wire

>>> design/rae_regfile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rae_regfile
// Register file memory: one write port, two registered read ports. A valid
// bit per entry, cleared by reset, makes never-written entries read as zero.
// ----------------------------------------------------------------------------
module rae_regfile #(
  parameter int DEPTH      = rae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rae_pkg::DATA_WIDTH_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr_a,
  input  wire logic [AW-1:0]         rd_addr_b,
  output logic      [DATA_WIDTH-1:0] rd_data_a,
  output logic      [DATA_WIDTH-1:0] rd_data_b,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data
);
  import rae_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vld;
  logic [DATA_WIDTH-1:0] q_a;
  logic [DATA_WIDTH-1:0] q_b;
  logic                  q_a_vld;
  logic                  q_b_vld;

  // write port and registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_a <= mem[rd_addr_a];
      q_b <= mem[rd_addr_b];
    end
  end

  // valid bits: clear on reset, set on write, sample on read
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      q_a_vld <= 1'b0;
      q_b_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_a_vld <= vld[rd_addr_a];
        q_b_vld <= vld[rd_addr_b];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_a = q_a_vld ? q_a : '0;
  assign rd_data_b = q_b_vld ? q_b : '0;

endmodule : rae_regfile
`default_nettype wire

>>> design/rae_serial_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rae_serial_alu
// Shared serial execution unit. Logic and add/sub ops run one bit per cycle
// through shift registers; multiply is shift-and-add; divide and remainder
// use a restoring divider on magnitudes. All but a zero-divisor div or rem take DATA_WIDTH steps.
// ----------------------------------------------------------------------------
module rae_serial_alu #(
  parameter int DATA_WIDTH = rae_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rae_pkg::alu_cmd_t     cmd,
  input  wire logic [DATA_WIDTH-1:0] opa,
  input  wire logic [DATA_WIDTH-1:0] opb,
  output logic      [DATA_WIDTH-1:0] res,
  output rae_pkg::alu_stat_t         stat
);
  import rae_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_RUN  = 3'b010,
    E_FIX  = 3'b100
  } eng_state_t;

  eng_state_t            state;
  logic [CW-1:0]         cnt;
  logic                  done;
  op_t                   op;
  logic [DATA_WIDTH-1:0] sa;
  logic [DATA_WIDTH-1:0] sb;
  logic [DATA_WIDTH-1:0] acc;
  logic                  carry;
  logic                  zero;
  logic                  neg_a;
  logic                  neg_q;

  logic                  a_neg_in;
  logic                  b_neg_in;
  logic                  bit_out;
  logic                  carry_next;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH-1:0] addend;
  logic                  fits;

  assign a_neg_in = opa[DATA_WIDTH-1];
  assign b_neg_in = opb[DATA_WIDTH-1];

  // one bit of the serial ops
  always_comb begin
    carry_next = carry;
    unique case (op)
      OP_MOV: bit_out = sb[0];
      OP_AND: bit_out = sa[0] & sb[0];
      OP_OR:  bit_out = sa[0] | sb[0];
      OP_ADD, OP_SUB: begin
        bit_out    = sa[0] ^ sb[0] ^ carry;
        carry_next = (sa[0] & sb[0]) | (carry & (sa[0] ^ sb[0]));
      end
      default: bit_out = 1'b0;
    endcase
  end

  // multiply partial product and divide trial
  assign addend  = sb[0] ? sa : '0;
  assign shifted = {acc[DATA_WIDTH-2:0], sa[DATA_WIDTH-1]};
  assign fits    = (shifted >= sb);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == E_FIX);
      unique case (state)
        E_IDLE: begin
          if (cmd.start) begin
            cnt <= CW'(DATA_WIDTH - 1);
            if ((cmd.op == OP_DIV || cmd.op == OP_REM) && opb == '0) begin
              state <= E_FIX;
            end else begin
              state <= E_RUN;
            end
          end
        end
        E_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= E_FIX;
          end
        end
        E_FIX: begin
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE: begin
        if (cmd.start) begin
          op    <= cmd.op;
          acc   <= '0;
          carry <= (cmd.op == OP_SUB);
          zero  <= (cmd.op == OP_DIV || cmd.op == OP_REM) && (opb == '0);
          neg_a <= a_neg_in;
          neg_q <= a_neg_in ^ b_neg_in;
          unique case (cmd.op)
            OP_DIV, OP_REM: begin
              sa <= a_neg_in ? (DATA_WIDTH'(0) - opa) : opa;
              sb <= b_neg_in ? (DATA_WIDTH'(0) - opb) : opb;
            end
            OP_SUB: begin
              sa <= opa;
              sb <= ~opb;
            end
            default: begin
              sa <= opa;
              sb <= opb;
            end
          endcase
        end
      end
      E_RUN: begin
        unique case (op)
          OP_MUL: begin
            acc <= acc + addend;
            sa  <= {sa[DATA_WIDTH-2:0], 1'b0};
            sb  <= {1'b0, sb[DATA_WIDTH-1:1]};
          end
          OP_DIV, OP_REM: begin
            acc <= fits ? (shifted - sb) : shifted;
            sa  <= {sa[DATA_WIDTH-2:0], fits};
          end
          default: begin
            acc   <= {bit_out, acc[DATA_WIDTH-1:1]};
            sa    <= {1'b0, sa[DATA_WIDTH-1:1]};
            sb    <= {1'b0, sb[DATA_WIDTH-1:1]};
            carry <= carry_next;
          end
        endcase
      end
      E_FIX: begin
        // apply signs of quotient and remainder
        unique case (op)
          OP_DIV:  res <= neg_q ? (DATA_WIDTH'(0) - sa) : sa;
          OP_REM:  res <= neg_a ? (DATA_WIDTH'(0) - acc) : acc;
          default: res <= acc;
        endcase
      end
      default: ;
    endcase
  end

  assign stat.done     = done;
  assign stat.div_zero = zero;

endmodule : rae_serial_alu
`default_nettype wire

>>> design/register_alu_execute.sv
`default_nettype none
// Flow: an accepted item passes register read, the serial ALU and write back;
//   a zero-divisor div or rem skips the serial steps. One item is in flight at a time.
// Throughput: a new item is accepted only once the previous one has written back,
//   which waits on the serial ALU steps; a waiting result does not block accept.
// Reset: synchronous; clears register valid bits and read/write marks at once,
//   so all registers read as zero and an item is taken the cycle after reset.
// ----------------------------------------------------------------------------
// register_alu_execute
// Register file execute unit: reads up to two registers, runs mov, add, sub,
// mul, div, rem, and, or on a serial ALU, writes the destination register and
// tracks which registers have been read and written.
// ----------------------------------------------------------------------------
module register_alu_execute #(
  parameter int NUM_REGS   = rae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rae_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rae_pkg::KIND_W-1:0]     kind,
  input  wire logic [rae_pkg::REG_IDX_W-1:0]  dest_reg,
  input  wire logic [rae_pkg::REG_IDX_W-1:0]  src_a_reg,
  input  wire logic [rae_pkg::REG_IDX_W-1:0]  src_b_reg,
  input  wire logic                           use_imm,
  input  wire logic signed [rae_pkg::FIELD_W-1:0] imm_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [rae_pkg::FIELD_W-1:0]  result_value,
  output logic                                div_error,
  output logic      [rae_pkg::FIELD_W-1:0]    read_mask,
  output logic      [rae_pkg::FIELD_W-1:0]    write_mask
);
  import rae_pkg::*;

  // only the first 2^REG_IDX_W registers are reachable by an index
  localparam int DEPTH = (NUM_REGS < (1 << REG_IDX_W)) ? NUM_REGS : (1 << REG_IDX_W);
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  state_t                 state;
  op_t                    op_q;
  logic [REG_IDX_W-1:0]   dest_q;
  logic                   dest_ok;
  logic                   a_ok;
  logic                   b_ok;
  logic                   use_imm_q;
  logic [DATA_WIDTH-1:0]  imm_q;
  logic [FIELD_W-1:0]     reads_seen;
  logic [FIELD_W-1:0]     writes_seen;

  logic                   accept;
  logic                   wb_fire;
  logic                   a_ok_in;
  logic                   b_ok_in;
  logic                   rf_we;
  logic [DATA_WIDTH-1:0]  rf_rd_a;
  logic [DATA_WIDTH-1:0]  rf_rd_b;
  logic [DATA_WIDTH-1:0]  opa;
  logic [DATA_WIDTH-1:0]  opb;
  logic [DATA_WIDTH-1:0]  eng_res;
  alu_cmd_t               eng_cmd;
  alu_stat_t              eng_stat;
  logic [FIELD_W-1:0]     wr_bit;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wb_fire  = (state == S_WB) && (!out_valid || !out_stall);

  // source register usage of the incoming item
  assign a_ok_in = (op_t'(kind) != OP_MOV) && (32'(src_a_reg) < DEPTH);
  assign b_ok_in = !use_imm && (32'(src_b_reg) < DEPTH);

  // register file
  rae_regfile #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (src_a_reg[AW-1:0]),
    .rd_addr_b (src_b_reg[AW-1:0]),
    .rd_data_a (rf_rd_a),
    .rd_data_b (rf_rd_b),
    .wr_en     (rf_we),
    .wr_addr   (dest_q[AW-1:0]),
    .wr_data   (eng_res)
  );

  // operand select and ALU start
  assign opa             = a_ok ? rf_rd_a : '0;
  assign opb             = use_imm_q ? imm_q : (b_ok ? rf_rd_b : '0);
  assign eng_cmd.start   = (state == S_READ);
  assign eng_cmd.op      = op_q;

  rae_serial_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (eng_cmd),
    .opa  (opa),
    .opb  (opb),
    .res  (eng_res),
    .stat (eng_stat)
  );

  // write back: drop on zero divisor or out-of-range destination
  assign rf_we  = wb_fire && !eng_stat.div_zero && dest_ok;
  assign wr_bit = rf_we ? (FIELD_W'(1) << dest_q) : '0;

  // item fields held for the whole item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_t'(kind);
      dest_q    <= dest_reg;
      dest_ok   <= (32'(dest_reg) < DEPTH);
      a_ok      <= a_ok_in;
      b_ok      <= b_ok_in;
      use_imm_q <= use_imm;
      imm_q     <= DATA_WIDTH'($signed(imm_value));
    end
  end

  // sequencer and marks
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      reads_seen  <= '0;
      writes_seen <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            reads_seen <= reads_seen
                        | (a_ok_in ? (FIELD_W'(1) << src_a_reg) : '0)
                        | (b_ok_in ? (FIELD_W'(1) << src_b_reg) : '0);
            state      <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (eng_stat.done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (wb_fire) begin
            writes_seen <= writes_seen | wr_bit;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      result_value <= eng_stat.div_zero ? '0 : FIELD_W'($signed(eng_res));
      div_error    <= eng_stat.div_zero;
      read_mask    <= reads_seen;
      write_mask   <= writes_seen | wr_bit;
    end
  end

  // checks
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted item did not move to register read");

  a_no_write_on_err: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> (!eng_stat.div_zero && state == S_WB))
    else $error("register written outside write back or on zero divisor");

  a_done_in_exec: assert property (@(posedge clk) disable iff (rst)
    eng_stat.done |-> (state == S_EXEC))
    else $error("ALU finished while no item was executing");

  a_marks_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |->
      (((reads_seen & $past(reads_seen)) == $past(reads_seen)) &&
       ((writes_seen & $past(writes_seen)) == $past(writes_seen))))
    else $error("read or write mark was cleared");

  a_err_zero_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && div_error) |-> (result_value == '0))
    else $error("zero-divisor result carries a nonzero value");

endmodule : register_alu_execute
`default_nettype wire

>>> test/register_alu_execute_tb.sv
// ----------------------------------------------------------------------------
// register_alu_execute_tb
// Self-checking bench for the register ALU execute block. Items are driven
// through a valid/stall handshake and run through a local model of the
// register file, the ALU and the read/write marks. Each result that comes out
// is compared field by field against the oldest pending prediction. Both
// sides idle and stall at random. One phase holds the output off for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module register_alu_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rae_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 45;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [31:0] value;
    logic        fault;
    logic [31:0] rmask;
    logic [31:0] wmask;
  } exec_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [2:0]  kind      = '0;
  logic [4:0]  dest_reg  = '0;
  logic [4:0]  src_a_reg = '0;
  logic [4:0]  src_b_reg = '0;
  logic        use_imm   = 1'b0;
  logic signed [31:0] imm_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic signed [31:0] result_value;
  logic        div_error;
  logic [31:0] read_mask;
  logic [31:0] write_mask;

  // model state of the register file and the marks
  logic [31:0] gpr [32];
  logic [31:0] reads_mark  = '0;
  logic [31:0] writes_mark = '0;

  exec_result_t pending_results[$];
  int  mismatch_count = 0;
  int  stalled_cycles = 0;
  int  hold_left      = 0;
  bit  no_idle        = 1'b0;
  bit  hold_req       = 1'b0;

  register_alu_execute u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .dest_reg     (dest_reg),
    .src_a_reg    (src_a_reg),
    .src_b_reg    (src_b_reg),
    .use_imm      (use_imm),
    .imm_value    (imm_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .div_error    (div_error),
    .read_mask    (read_mask),
    .write_mask   (write_mask)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
  end

  // Execute one item on the model and queue the result it must produce
  function automatic void execute_item(input op_t op, input logic [4:0] rd, ra, rb,
                                       input logic imm_sel, input logic [31:0] imm);
    logic [31:0] a, b, res, ma, mb, q;
    logic        fault;
    exec_result_t exp_r;
    a     = '0;
    res   = '0;
    fault = 1'b0;
    if (op != OP_MOV) begin
      a = gpr[ra];
      reads_mark[ra] = 1'b1;
    end
    if (imm_sel) begin
      b = imm;
    end else begin
      b = gpr[rb];
      reads_mark[rb] = 1'b1;
    end
    case (op)
      OP_MOV: res = b;
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_MUL: res = a * b;
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          fault = 1'b1;
        end else begin
          // divide magnitudes, then fix the sign (truncate toward zero)
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          if (op == OP_DIV) begin
            q   = ma / mb;
            res = (a[31] ^ b[31]) ? -q : q;
          end else begin
            q   = ma % mb;
            res = a[31] ? -q : q;
          end
        end
      end
      OP_AND: res = a & b;
      default: res = a | b;
    endcase
    if (!fault) begin
      gpr[rd] = res;
      writes_mark[rd] = 1'b1;
    end
    exp_r.value = res;
    exp_r.fault = fault;
    exp_r.rmask = reads_mark;
    exp_r.wmask = writes_mark;
    pending_results.push_back(exp_r);
  endfunction

  // Offer one item, with an optional random gap first; return at its accept edge
  task automatic send_item(input op_t op, input logic [4:0] rd, ra, rb,
                           input logic imm_sel, input logic [31:0] imm);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= op;
    dest_reg  <= rd;
    src_a_reg <= ra;
    src_b_reg <= rb;
    use_imm   <= imm_sel;
    imm_value <= imm;
    do @(posedge clk); while (in_stall);
    execute_item(op, rd, ra, rb, imm_sel, imm);
  endtask

  // Operand values weighted toward the corners of 32-bit arithmetic
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($urandom_range(0, 31)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  // Half the indexes come from a small pool so results feed later items
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic send_random_items(input int count);
    for (int n = 0; n < count; n++) begin
      send_item(op_t'($urandom_range(0, 7)), pick_reg(), pick_reg(), pick_reg(),
                1'($urandom_range(0, 1)), pick_operand());
    end
  endtask

  // Extremes, every operation, zero divisors and the overflowing divide
  task automatic test_directed_ops();
    send_item(OP_MOV, 5'd1,  5'd0,  5'd0,  1'b1, 32'h7FFF_FFFF);
    send_item(OP_MOV, 5'd2,  5'd0,  5'd0,  1'b1, 32'h8000_0000);
    send_item(OP_MOV, 5'd3,  5'd0,  5'd0,  1'b1, 32'hFFFF_FFFF);
    send_item(OP_MOV, 5'd31, 5'd0,  5'd0,  1'b1, 32'h5A5A_A5A5);
    send_item(OP_MOV, 5'd4,  5'd7,  5'd1,  1'b0, 32'h0);
    send_item(OP_ADD, 5'd5,  5'd1,  5'd0,  1'b1, 32'd1);
    send_item(OP_SUB, 5'd6,  5'd2,  5'd0,  1'b1, 32'd1);
    send_item(OP_ADD, 5'd7,  5'd1,  5'd3,  1'b0, 32'h0);
    send_item(OP_MUL, 5'd8,  5'd1,  5'd1,  1'b0, 32'h0);
    send_item(OP_MUL, 5'd9,  5'd2,  5'd0,  1'b1, 32'hFFFF_FFFF);
    // most negative value over minus one wraps
    send_item(OP_DIV, 5'd10, 5'd2,  5'd3,  1'b0, 32'h0);
    send_item(OP_REM, 5'd11, 5'd2,  5'd3,  1'b0, 32'h0);
    // zero divisors from the immediate and from a register never written
    send_item(OP_DIV, 5'd12, 5'd1,  5'd0,  1'b1, 32'h0);
    send_item(OP_REM, 5'd13, 5'd1,  5'd20, 1'b0, 32'h0);
    send_item(OP_DIV, 5'd14, 5'd2,  5'd0,  1'b1, 32'd7);
    send_item(OP_REM, 5'd15, 5'd2,  5'd0,  1'b1, 32'hFFFF_FFF9);
    send_item(OP_DIV, 5'd16, 5'd31, 5'd3,  1'b0, 32'h0);
    send_item(OP_REM, 5'd17, 5'd1,  5'd31, 1'b0, 32'h0);
    send_item(OP_AND, 5'd18, 5'd31, 5'd0,  1'b1, 32'hFFFF_0000);
    send_item(OP_OR,  5'd19, 5'd31, 5'd2,  1'b0, 32'h0);
    send_item(OP_DIV, 5'd1,  5'd1,  5'd1,  1'b0, 32'h0);
    send_item(OP_MOV, 5'd0,  5'd0,  5'd0,  1'b1, 32'h0);
  endtask

  task automatic test_random_steady();
    no_idle = 1'b1;
    send_random_items(250);
    no_idle = 1'b0;
  endtask

  task automatic test_random_mixed();
    send_random_items(850);
  endtask

  // Hold the output off while items keep coming so the input backs up
  task automatic test_output_holdoff();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    send_random_items(100);
    no_idle  = 1'b0;
  endtask

  // Drive the output stall: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 29);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    exec_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: value=%h err=%b rmask=%h wmask=%h",
                   result_value, div_error, read_mask, write_mask);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_value !== exp_r.value || div_error !== exp_r.fault ||
            read_mask !== exp_r.rmask || write_mask !== exp_r.wmask) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp value=%h err=%b rmask=%h wmask=%h, got %h %b %h %h",
                     exp_r.value, exp_r.fault, exp_r.rmask, exp_r.wmask,
                     result_value, div_error, read_mask, write_mask);
        end
      end
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_random_steady();
    test_random_mixed();
    test_output_holdoff();
    in_valid <= 1'b0;
    // drain the last results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rae_pkg.sv
design/rae_regfile.sv
design/rae_serial_alu.sv
design/register_alu_execute.sv
test/register_alu_execute_tb.sv
